### hw/rtl/vna_pkg.sv
`default_nettype none

package vna_pkg;

  localparam int unsigned VERTEX_DEPTH_DEF  = 1024;
  localparam int unsigned POSITION_BITS_DEF = 16;
  localparam int unsigned SUM_BITS_DEF      = 48;

  localparam int unsigned IDX_W     = 10;
  localparam int unsigned IDX_EXT_W = 17;
  localparam int unsigned FIELD_W   = 16;
  localparam int unsigned CNT_W     = 16;

  localparam int unsigned QUEUE_DEPTH = 4;
  localparam int unsigned QPTR_W      = 2;
  localparam int unsigned QCNT_W      = 3;

  localparam int unsigned MAG_W     = 31;
  localparam int unsigned SQ_W      = 64;
  localparam int unsigned ROOT_W    = 32;
  localparam int unsigned NUM_W     = 46;
  localparam int unsigned QUO_W     = 15;
  localparam int unsigned ONE_SHIFT = 14;

  typedef enum logic [1:0] {
    OP_LOAD  = 2'd0,
    OP_TRI   = 2'd1,
    OP_QUERY = 2'd2,
    OP_CLEAR = 2'd3
  } op_e;

  typedef struct packed {
    logic [1:0]               req_type;
    logic [IDX_W-1:0]         vertex_index;
    logic signed [FIELD_W-1:0] pos_x;
    logic signed [FIELD_W-1:0] pos_y;
    logic signed [FIELD_W-1:0] pos_z;
    logic [IDX_W-1:0]         corner_a;
    logic [IDX_W-1:0]         corner_b;
    logic [IDX_W-1:0]         corner_c;
  } in_t;

  typedef struct packed {
    logic [IDX_W-1:0]          normal_vertex;
    logic signed [FIELD_W-1:0] normal_x;
    logic signed [FIELD_W-1:0] normal_y;
    logic signed [FIELD_W-1:0] normal_z;
    logic                      has_normal;
  } out_t;

  typedef struct packed {
    op_e                       op;
    logic                      in_range;
    logic [IDX_W-1:0]          vertex_index;
    logic signed [FIELD_W-1:0] pos_x;
    logic signed [FIELD_W-1:0] pos_y;
    logic signed [FIELD_W-1:0] pos_z;
    logic [IDX_W-1:0]          corner_a;
    logic [IDX_W-1:0]          corner_b;
    logic [IDX_W-1:0]          corner_c;
  } cmd_t;

  typedef struct packed {
    logic              full;
    logic              empty;
    logic [QCNT_W-1:0] count;
  } q_stat_t;

  typedef struct packed {
    logic clearing;
    logic putting;
  } back_stat_t;

endpackage

`default_nettype wire

### hw/rtl/vna_front.sv
`default_nettype none

module vna_front import vna_pkg::*; #(
  parameter int unsigned VERTEX_DEPTH = VERTEX_DEPTH_DEF
) (
  input  wire logic    in_valid_i,
  input  wire in_t     in_data_i,
  output logic         in_ready_o,
  input  wire q_stat_t q_stat_i,
  output logic         push_o,
  output cmd_t         cmd_o
);

  localparam logic [IDX_EXT_W-1:0] DEPTH_EXT = IDX_EXT_W'(VERTEX_DEPTH);

  op_e  op;
  logic v_ok, a_ok, b_ok, c_ok, keep;

  always_comb begin
    op   = op_e'(in_data_i.req_type);
    v_ok = IDX_EXT_W'(in_data_i.vertex_index) < DEPTH_EXT;
    a_ok = IDX_EXT_W'(in_data_i.corner_a) < DEPTH_EXT;
    b_ok = IDX_EXT_W'(in_data_i.corner_b) < DEPTH_EXT;
    c_ok = IDX_EXT_W'(in_data_i.corner_c) < DEPTH_EXT;

    cmd_o.op           = op;
    cmd_o.in_range     = v_ok;
    cmd_o.vertex_index = in_data_i.vertex_index;
    cmd_o.pos_x        = in_data_i.pos_x;
    cmd_o.pos_y        = in_data_i.pos_y;
    cmd_o.pos_z        = in_data_i.pos_z;
    cmd_o.corner_a     = in_data_i.corner_a;
    cmd_o.corner_b     = in_data_i.corner_b;
    cmd_o.corner_c     = in_data_i.corner_c;

    // loads to an out-of-range vertex and triangles with any corner out of range are dropped here
    case (op)
      OP_LOAD: keep = v_ok;
      OP_TRI: begin
        keep           = a_ok & b_ok & c_ok;
        cmd_o.in_range = keep;
      end
      default: keep = 1'b1;
    endcase

    in_ready_o = ~q_stat_i.full;
    push_o     = in_valid_i & in_ready_o & keep;
  end

endmodule

`default_nettype wire

### hw/rtl/vna_fifo.sv
`default_nettype none

module vna_fifo import vna_pkg::*; (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  input  wire logic push_i,
  input  wire cmd_t cmd_i,
  input  wire logic pop_i,
  output logic      valid_o,
  output cmd_t      cmd_o,
  output q_stat_t   stat_o
);

  cmd_t              mem_q [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_q, rd_q;
  logic [QCNT_W-1:0] cnt_q;
  logic              do_push, do_pop;

  always_comb begin
    stat_o.count = cnt_q;
    stat_o.empty = cnt_q == '0;
    stat_o.full  = cnt_q == QCNT_W'(QUEUE_DEPTH);
    valid_o      = ~stat_o.empty;
    cmd_o        = mem_q[rd_q];
    do_push      = push_i & ~stat_o.full;
    do_pop       = pop_i & ~stat_o.empty;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (do_push) wr_q <= wr_q + 1'b1;
      if (do_pop)  rd_q <= rd_q + 1'b1;
      if (do_push && !do_pop) cnt_q <= cnt_q + 1'b1;
      else if (!do_push && do_pop) cnt_q <= cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) mem_q[wr_q] <= cmd_i;
  end

endmodule

`default_nettype wire

### hw/rtl/vna_norm.sv
`default_nettype none

module vna_norm import vna_pkg::*; #(
  parameter int unsigned SUM_BITS = SUM_BITS_DEF
) (
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  input  wire logic                  start_i,
  input  wire logic [3*SUM_BITS-1:0] sum_i,
  output logic                       done_o,
  output logic [3*FIELD_W-1:0]       norm_o
);

  localparam logic [SUM_BITS-1:0] LIM_LO = SUM_BITS'(1) << (MAG_W - 1);
  localparam logic [SUM_BITS-1:0] LIM_HI = SUM_BITS'(1) << MAG_W;
  localparam logic [SQ_W-1:0]     BIT_TOP = SQ_W'(1) << (SQ_W - 2);

  typedef enum logic [5:0] {
    N_IDLE = 6'b000001,
    N_SHF  = 6'b000010,
    N_SQ   = 6'b000100,
    N_RT   = 6'b001000,
    N_LD   = 6'b010000,
    N_DV   = 6'b100000
  } nstate_e;

  nstate_e               state_q;
  logic [SUM_BITS-1:0]   mag_q [3];
  logic                  neg_q [3];
  logic [SUM_BITS-1:0]   big_q;
  logic [1:0]            k_q;
  logic [SQ_W-1:0]       acc_q, x_q, res_q, bit_q;
  logic [ROOT_W-1:0]     len_q, rem_q;
  logic [QUO_W-1:0]      low_q, quo_q;
  logic [3:0]            step_q;
  logic [FIELD_W-1:0]    nrm_q [3];
  logic                  done_q;

  logic signed [SUM_BITS-1:0] s [3];
  logic [SUM_BITS-1:0]        m [3];
  logic [SUM_BITS-1:0]        big;
  logic [MAG_W-1:0]           msel;
  logic [2*MAG_W-1:0]         sqr;
  logic [SQ_W-1:0]            rt_t, rt_x, rt_res;
  logic [NUM_W-1:0]           num;
  logic [ROOT_W:0]            r2, r2s;
  logic                       ge;
  logic [QUO_W-1:0]           quo;

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      s[i] = $signed(sum_i[i*SUM_BITS +: SUM_BITS]);
      m[i] = s[i][SUM_BITS-1] ? SUM_BITS'(-s[i]) : SUM_BITS'(s[i]);
    end
    big = m[0];
    if (m[1] > big) big = m[1];
    if (m[2] > big) big = m[2];

    msel = mag_q[k_q][MAG_W-1:0];
    sqr  = msel * msel;

    rt_t = res_q + bit_q;
    if (x_q >= rt_t) begin
      rt_x   = x_q - rt_t;
      rt_res = (res_q >> 1) + bit_q;
    end else begin
      rt_x   = x_q;
      rt_res = res_q >> 1;
    end

    num = (NUM_W'(msel) << ONE_SHIFT) + NUM_W'(len_q >> 1);
    r2  = {rem_q, low_q[QUO_W-1]};
    ge  = r2 >= {1'b0, len_q};
    r2s = ge ? r2 - {1'b0, len_q} : r2;
    quo = {quo_q[QUO_W-2:0], ge};

    done_o = done_q;
    for (int i = 0; i < 3; i++) norm_o[i*FIELD_W +: FIELD_W] = nrm_q[i];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= N_IDLE;
      done_q  <= 1'b0;
      k_q     <= '0;
      step_q  <= '0;
    end else begin
      done_q <= (state_q == N_IDLE && start_i && big == '0) ||
                (state_q == N_DV && step_q == 4'(QUO_W - 1) && k_q == 2'd2);
      case (state_q)
        N_IDLE: begin
          if (start_i && big != '0) state_q <= N_SHF;
        end
        N_SHF: begin
          if (big_q >= LIM_LO && big_q < LIM_HI) begin
            state_q <= N_SQ;
            k_q     <= '0;
          end
        end
        N_SQ: begin
          if (k_q == 2'd2) state_q <= N_RT;
          else k_q <= k_q + 1'b1;
        end
        N_RT: begin
          if (bit_q == SQ_W'(1)) begin
            state_q <= N_LD;
            k_q     <= '0;
          end
        end
        N_LD: begin
          state_q <= N_DV;
          step_q  <= '0;
        end
        N_DV: begin
          step_q <= step_q + 1'b1;
          if (step_q == 4'(QUO_W - 1)) begin
            if (k_q == 2'd2) begin
              state_q <= N_IDLE;
            end else begin
              k_q     <= k_q + 1'b1;
              state_q <= N_LD;
            end
          end
        end
        default: state_q <= N_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    case (state_q)
      N_IDLE: begin
        if (start_i) begin
          for (int i = 0; i < 3; i++) begin
            mag_q[i] <= m[i];
            neg_q[i] <= s[i][SUM_BITS-1];
            nrm_q[i] <= '0;
          end
          big_q <= big;
        end
      end
      N_SHF: begin
        if (big_q < LIM_LO) begin
          big_q <= big_q << 1;
          for (int i = 0; i < 3; i++) mag_q[i] <= mag_q[i] << 1;
        end else if (big_q >= LIM_HI) begin
          big_q <= big_q >> 1;
          for (int i = 0; i < 3; i++) mag_q[i] <= mag_q[i] >> 1;
        end
        acc_q <= '0;
      end
      N_SQ: begin
        acc_q <= acc_q + SQ_W'(sqr);
        x_q   <= acc_q + SQ_W'(sqr);
        res_q <= '0;
        bit_q <= BIT_TOP;
      end
      N_RT: begin
        x_q   <= rt_x;
        res_q <= rt_res;
        bit_q <= bit_q >> 2;
        len_q <= rt_res[ROOT_W-1:0];
      end
      N_LD: begin
        rem_q <= ROOT_W'(num[NUM_W-1:QUO_W]);
        low_q <= num[QUO_W-1:0];
        quo_q <= '0;
      end
      N_DV: begin
        rem_q <= r2s[ROOT_W-1:0];
        low_q <= low_q << 1;
        quo_q <= quo;
        if (step_q == 4'(QUO_W - 1)) begin
          nrm_q[k_q] <= neg_q[k_q] ? -FIELD_W'(quo) : FIELD_W'(quo);
        end
      end
      default: ;
    endcase
  end

endmodule

`default_nettype wire

### hw/rtl/vna_back.sv
`default_nettype none

module vna_back import vna_pkg::*; #(
  parameter int unsigned VERTEX_DEPTH  = VERTEX_DEPTH_DEF,
  parameter int unsigned POSITION_BITS = POSITION_BITS_DEF,
  parameter int unsigned SUM_BITS      = SUM_BITS_DEF
) (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  input  wire logic cmd_valid_i,
  input  wire cmd_t cmd_i,
  output logic      cmd_pop_o,
  output logic      out_valid_o,
  input  wire logic out_ready_i,
  output out_t      out_data_o,
  output back_stat_t stat_o
);

  localparam int unsigned AW   = $clog2(VERTEX_DEPTH);
  localparam int unsigned PW   = POSITION_BITS;
  localparam int unsigned EW   = PW + 1;
  localparam int unsigned PRW  = 2 * EW;
  localparam int unsigned FW   = PRW + 1;
  localparam int unsigned XW   = (SUM_BITS > FW ? SUM_BITS : FW) + 1;
  localparam int unsigned POSW = 3 * PW;
  localparam int unsigned SEW  = 3 * SUM_BITS + CNT_W;
  localparam logic [AW-1:0] LAST_ADDR = AW'(VERTEX_DEPTH - 1);

  typedef enum logic [13:0] {
    S_CLR  = 14'b00000000000001,
    S_IDLE = 14'b00000000000010,
    S_RDA  = 14'b00000000000100,
    S_RDB  = 14'b00000000001000,
    S_RDC  = 14'b00000000010000,
    S_DIF  = 14'b00000000100000,
    S_MUL  = 14'b00000001000000,
    S_CRS  = 14'b00000010000000,
    S_SRD  = 14'b00000100000000,
    S_SWR  = 14'b00001000000000,
    S_QRD  = 14'b00010000000000,
    S_QST  = 14'b00100000000000,
    S_QNM  = 14'b01000000000000,
    S_PUT  = 14'b10000000000000
  } state_e;

  function automatic logic [AW-1:0] to_addr(logic [IDX_W-1:0] idx);
    logic [IDX_EXT_W-1:0] e;
    e = IDX_EXT_W'(idx);
    return e[AW-1:0];
  endfunction

  function automatic logic [PW-1:0] trim(logic signed [FIELD_W-1:0] v);
    logic signed [31:0] w;
    w = 32'(v);
    return w[PW-1:0];
  endfunction

  function automatic logic signed [SUM_BITS-1:0] sat_add(logic signed [SUM_BITS-1:0] s,
                                                         logic signed [FW-1:0] f);
    logic signed [XW-1:0] t, hi, lo;
    t  = XW'(s) + XW'(f);
    hi = XW'($signed({1'b0, {(SUM_BITS-1){1'b1}}}));
    lo = ~hi;
    if (t > hi) return hi[SUM_BITS-1:0];
    if (t < lo) return lo[SUM_BITS-1:0];
    return t[SUM_BITS-1:0];
  endfunction

  state_e            state_q;
  logic [AW-1:0]     clr_q;
  logic [1:0]        corner_q;
  cmd_t              cmd_q;
  logic [POSW-1:0]   pa_q, pb_q;
  logic signed [EW-1:0]  e1_q [3], e2_q [3];
  logic signed [PRW-1:0] prod_q [6];
  logic signed [FW-1:0]  face_q [3];
  out_t              res_q, out_q;
  logic              out_valid_q;

  logic [POSW-1:0]   pos_mem [VERTEX_DEPTH];
  logic [POSW-1:0]   pos_rd_q, pos_wd;
  logic [AW-1:0]     pos_addr;
  logic              pos_we;

  logic [SEW-1:0]    sum_mem [VERTEX_DEPTH];
  logic [SEW-1:0]    sum_rd_q, sum_wd;
  logic [AW-1:0]     sum_addr, corner_addr;
  logic              sum_we;

  logic [CNT_W-1:0]  cnt_rd;
  logic              norm_start, norm_done;
  logic [3*FIELD_W-1:0] norm_vec;
  logic              out_free;

  vna_norm #(
    .SUM_BITS (SUM_BITS)
  ) u_norm (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (norm_start),
    .sum_i   (sum_rd_q[3*SUM_BITS-1:0]),
    .done_o  (norm_done),
    .norm_o  (norm_vec)
  );

  always_comb begin
    case (corner_q)
      2'd0:    corner_addr = to_addr(cmd_q.corner_a);
      2'd1:    corner_addr = to_addr(cmd_q.corner_b);
      default: corner_addr = to_addr(cmd_q.corner_c);
    endcase
    cnt_rd   = sum_rd_q[SEW-1 -: CNT_W];
    out_free = ~out_valid_q | out_ready_i;

    pos_we     = 1'b0;
    pos_addr   = to_addr(cmd_i.vertex_index);
    pos_wd     = {trim(cmd_i.pos_z), trim(cmd_i.pos_y), trim(cmd_i.pos_x)};
    sum_we     = 1'b0;
    sum_addr   = clr_q;
    sum_wd     = '0;
    cmd_pop_o  = 1'b0;
    norm_start = 1'b0;

    for (int i = 0; i < 3; i++) begin
      sum_wd[i*SUM_BITS +: SUM_BITS] =
        sat_add($signed(sum_rd_q[i*SUM_BITS +: SUM_BITS]), face_q[i]);
    end
    sum_wd[SEW-1 -: CNT_W] = (cnt_rd == '1) ? cnt_rd : cnt_rd + 1'b1;

    case (state_q)
      S_CLR: begin
        sum_we = 1'b1;
        sum_wd = '0;
      end
      S_IDLE: begin
        cmd_pop_o = cmd_valid_i;
        pos_we    = cmd_valid_i & (cmd_i.op == OP_LOAD) & cmd_i.in_range;
      end
      S_RDA:   pos_addr = to_addr(cmd_q.corner_a);
      S_RDB:   pos_addr = to_addr(cmd_q.corner_b);
      S_RDC:   pos_addr = to_addr(cmd_q.corner_c);
      S_SRD:   sum_addr = corner_addr;
      S_SWR: begin
        sum_addr = corner_addr;
        sum_we   = 1'b1;
      end
      S_QRD:   sum_addr = to_addr(cmd_q.vertex_index);
      S_QST:   norm_start = 1'b1;
      default: ;
    endcase

    out_valid_o     = out_valid_q;
    out_data_o      = out_q;
    stat_o.clearing = state_q == S_CLR;
    stat_o.putting  = state_q == S_PUT;
  end

  always_ff @(posedge clk_i) begin
    if (pos_we) pos_mem[pos_addr] <= pos_wd;
    pos_rd_q <= pos_mem[pos_addr];
  end

  always_ff @(posedge clk_i) begin
    if (sum_we) sum_mem[sum_addr] <= sum_wd;
    sum_rd_q <= sum_mem[sum_addr];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_CLR;
      clr_q       <= '0;
      corner_q    <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (out_valid_q && out_ready_i && state_q != S_PUT) out_valid_q <= 1'b0;
      case (state_q)
        S_CLR: begin
          clr_q <= clr_q + 1'b1;
          if (clr_q == LAST_ADDR) state_q <= S_IDLE;
        end
        S_IDLE: begin
          if (cmd_valid_i) begin
            case (cmd_i.op)
              OP_TRI:   state_q <= S_RDA;
              OP_QUERY: state_q <= cmd_i.in_range ? S_QRD : S_PUT;
              OP_CLEAR: begin
                state_q <= S_CLR;
                clr_q   <= '0;
              end
              default:  state_q <= S_IDLE;
            endcase
          end
        end
        S_RDA: state_q <= S_RDB;
        S_RDB: state_q <= S_RDC;
        S_RDC: state_q <= S_DIF;
        S_DIF: state_q <= S_MUL;
        S_MUL: state_q <= S_CRS;
        S_CRS: begin
          state_q  <= S_SRD;
          corner_q <= '0;
        end
        S_SRD: state_q <= S_SWR;
        S_SWR: begin
          if (corner_q == 2'd2) state_q <= S_IDLE;
          else begin
            corner_q <= corner_q + 1'b1;
            state_q  <= S_SRD;
          end
        end
        S_QRD: state_q <= S_QST;
        S_QST: state_q <= S_QNM;
        S_QNM: if (norm_done) state_q <= S_PUT;
        S_PUT: begin
          if (out_free) begin
            out_valid_q <= 1'b1;
            state_q     <= S_IDLE;
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    case (state_q)
      S_IDLE: begin
        if (cmd_valid_i) begin
          cmd_q <= cmd_i;
          res_q <= '{normal_vertex: cmd_i.vertex_index, default: '0};
        end
      end
      S_RDB: pa_q <= pos_rd_q;
      S_RDC: pb_q <= pos_rd_q;
      S_DIF: begin
        for (int i = 0; i < 3; i++) begin
          e1_q[i] <= EW'($signed(pb_q[i*PW +: PW])) - EW'($signed(pa_q[i*PW +: PW]));
          e2_q[i] <= EW'($signed(pos_rd_q[i*PW +: PW])) - EW'($signed(pa_q[i*PW +: PW]));
        end
      end
      S_MUL: begin
        prod_q[0] <= PRW'(e1_q[1]) * PRW'(e2_q[2]);
        prod_q[1] <= PRW'(e1_q[2]) * PRW'(e2_q[1]);
        prod_q[2] <= PRW'(e1_q[2]) * PRW'(e2_q[0]);
        prod_q[3] <= PRW'(e1_q[0]) * PRW'(e2_q[2]);
        prod_q[4] <= PRW'(e1_q[0]) * PRW'(e2_q[1]);
        prod_q[5] <= PRW'(e1_q[1]) * PRW'(e2_q[0]);
      end
      S_CRS: begin
        face_q[0] <= FW'(prod_q[0]) - FW'(prod_q[1]);
        face_q[1] <= FW'(prod_q[2]) - FW'(prod_q[3]);
        face_q[2] <= FW'(prod_q[4]) - FW'(prod_q[5]);
      end
      S_QST: res_q.has_normal <= cnt_rd != '0;
      S_QNM: begin
        if (norm_done) begin
          res_q.normal_x <= $signed(norm_vec[0 +: FIELD_W]);
          res_q.normal_y <= $signed(norm_vec[FIELD_W +: FIELD_W]);
          res_q.normal_z <= $signed(norm_vec[2*FIELD_W +: FIELD_W]);
        end
      end
      S_PUT: if (out_free) out_q <= res_q;
      default: ;
    endcase
  end

endmodule

`default_nettype wire

### hw/rtl/vertex_normal_accumulator_core.sv
// channel  | signals                               | beat moves when
// ---------+---------------------------------------+-------------------------
// request  | in_valid_i, in_ready_o, in_data_i     | in_valid_i & in_ready_o
// normal   | out_valid_o, out_ready_i, out_data_o  | out_valid_o & out_ready_i
//
// Position load: written in the executor's idle state. Triangle: three position
// reads then a read and a write of the sum store per corner, single port each.
// Query: set by the normaliser (shifts to bring the largest sum into range, three
// squares, 32 root steps, 16 load and divide steps per component); a zero sum
// skips those steps. Clear: a sweep of the whole sum store. After reset the
// sum store is swept to zero; the request queue still takes beats until it is
// full. A held result stalls only later queries.

`default_nettype none

module vertex_normal_accumulator_core import vna_pkg::*; #(
  parameter int unsigned VERTEX_DEPTH  = VERTEX_DEPTH_DEF,
  parameter int unsigned POSITION_BITS = POSITION_BITS_DEF,
  parameter int unsigned SUM_BITS      = SUM_BITS_DEF
) (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  input  wire logic in_valid_i,
  output logic      in_ready_o,
  input  wire in_t  in_data_i,
  output logic      out_valid_o,
  input  wire logic out_ready_i,
  output out_t      out_data_o
);

  q_stat_t    q_stat;
  back_stat_t b_stat;
  logic       push, cmd_valid, cmd_pop;
  cmd_t       push_cmd, head_cmd;

  vna_front #(
    .VERTEX_DEPTH (VERTEX_DEPTH)
  ) u_front (
    .in_valid_i (in_valid_i),
    .in_data_i  (in_data_i),
    .in_ready_o (in_ready_o),
    .q_stat_i   (q_stat),
    .push_o     (push),
    .cmd_o      (push_cmd)
  );

  vna_fifo u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .cmd_i   (push_cmd),
    .pop_i   (cmd_pop),
    .valid_o (cmd_valid),
    .cmd_o   (head_cmd),
    .stat_o  (q_stat)
  );

  vna_back #(
    .VERTEX_DEPTH  (VERTEX_DEPTH),
    .POSITION_BITS (POSITION_BITS),
    .SUM_BITS      (SUM_BITS)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_valid_i (cmd_valid),
    .cmd_i       (head_cmd),
    .cmd_pop_o   (cmd_pop),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_data_o  (out_data_o),
    .stat_o      (b_stat)
  );

  a_pop_nonempty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_pop |-> cmd_valid) else $error("pop from empty queue");

  a_queue_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    q_stat.count <= QCNT_W'(QUEUE_DEPTH)) else $error("queue overfilled");

  a_no_pop_clear: assert property (@(posedge clk_i) disable iff (!rst_ni)
    b_stat.clearing |-> !cmd_pop) else $error("beat taken during clear sweep");

  a_result_src: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> $past(b_stat.putting)) else $error("result without query");

endmodule

`default_nettype wire
